FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

FILE: rtl/core/lsfe_pkg.sv
// Shared constants, types and the symbol encoder of the LED strip frame encoder.
// No dependencies.
package lsfe_pkg;

    localparam int PIXEL_COUNT     = 15;
    localparam int LEAD_ZERO_BYTES = 16;
    localparam int TAIL_ZERO_BYTES = 64;

    localparam int PIX_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CNT_W   = $clog2(PIXEL_COUNT + 1);
    localparam int MASK_IW = 5;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] MODE_FILL    = 2'd0;
    localparam logic [1:0] MODE_MASKED  = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_REFRESH = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_GAP    = 2'd1;
    localparam logic [1:0] KIND_PIXEL  = 2'd2;

    localparam logic [2:0] SYM_ONE  = 3'b110;
    localparam logic [2:0] SYM_ZERO = 3'b100;

    typedef struct packed {
        logic [1:0]       op;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] stop;
        logic [31:0]      mask;
        logic [23:0]      colour;
        logic             rd_valid;
        logic [PIX_W-1:0] rd_idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  zero_bytes;
        logic [23:0] enc_green;
        logic [23:0] enc_red;
        logic [23:0] enc_blue;
        logic [7:0]  read_green;
        logic [7:0]  read_red;
        logic [7:0]  read_blue;
        logic        index_valid;
        logic        all_black;
        logic        last;
    } t_res;

    function automatic logic [23:0] enc_byte(input logic [7:0] b);
        logic [23:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            w[3*k +: 3] = b[k] ? SYM_ONE : SYM_ZERO;
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/lsfe_front.sv
// Front end: accepts commands, clips their pixel ranges and queues them.
// Depends on lsfe_pkg.
module lsfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_first,
    input  logic [7:0]        i_count,
    input  logic [7:0]        i_bound,
    input  logic [31:0]       i_mask,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_blue,
    output logic              o_cmd_valid,
    output lsfe_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import lsfe_pkg::*;

    localparam logic [8:0] N9 = 9'(PIXEL_COUNT);

    logic [8:0]         w_sum;
    logic               w_in_range;
    t_cmd               w_cmd;
    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_wr;
    logic               w_rd;

    assign w_sum      = {1'b0, i_first} + {1'b0, i_count};
    assign w_in_range = {1'b0, i_first} < N9;

    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = i_mode;
        w_cmd.mask     = i_mask;
        w_cmd.colour   = {i_green, i_red, i_blue};
        w_cmd.rd_valid = w_in_range;
        w_cmd.rd_idx   = w_in_range ? PIX_W'(i_first) : '0;
        unique case (i_mode)
            MODE_FILL: begin
                if (w_in_range) begin
                    w_cmd.start = CNT_W'(i_first);
                    w_cmd.stop  = (i_count == 8'd0 || w_sum >= N9) ?
                                  CNT_W'(PIXEL_COUNT) : CNT_W'(w_sum);
                end
            end
            MODE_MASKED: begin
                if (w_in_range && i_bound > i_first) begin
                    w_cmd.start = CNT_W'(i_first);
                    w_cmd.stop  = ({1'b0, i_bound} >= N9) ?
                                  CNT_W'(PIXEL_COUNT) : CNT_W'(i_bound);
                end
            end
            default: begin
            end
        endcase
    end

    assign full        = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (!w_wr && w_rd) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wr_ptr] <= w_cmd;
    end

endmodule

FILE: rtl/core/lsfe_back.sv
// Back end: pixel store and the sequencer that runs one command at a time.
// Depends on lsfe_pkg.
module lsfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lsfe_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_res_push,
    output lsfe_pkg::t_res o_res,
    input  logic           i_res_full
);
    import lsfe_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_STAT  = 4'd2;
    localparam logic [3:0] S_RDO   = 4'd3;
    localparam logic [3:0] S_LEAD  = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PEM   = 4'd6;
    localparam logic [3:0] S_TAIL  = 4'd7;

    logic [3:0]             r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_blk, n_blk;
    logic [PIXEL_COUNT-1:0] r_nz;
    logic [23:0]            r_mem [PIXEL_COUNT];
    logic [23:0]            r_rdata;
    logic                   r_rd_nz;
    logic [PIX_W-1:0]       w_rd_addr;
    logic [PIX_W-1:0]       w_wr_addr;
    logic                   w_wr_en;
    logic [23:0]            w_wr_data;
    logic [23:0]            w_colour;
    logic                   w_all_black;

    assign w_all_black = ~|r_nz;
    assign w_colour    = r_rd_nz ? r_rdata : 24'd0;
    assign w_wr_addr   = r_idx[PIX_W-1:0];
    assign w_wr_data   = (r_cmd.op == MODE_FILL || r_cmd.mask[MASK_IW'(w_wr_addr)]) ?
                         r_cmd.colour : 24'd0;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_blk      = r_blk;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        w_wr_en    = 1'b0;
        w_rd_addr  = r_idx[PIX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = i_cmd.rd_idx;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = i_cmd.start;
                    n_blk     = w_all_black;
                    unique case (i_cmd.op) inside
                        MODE_FILL, MODE_MASKED: n_state = S_WRITE;
                        MODE_READ: begin
                            n_idx   = CNT_W'(i_cmd.rd_idx);
                            n_state = S_RDO;
                        end
                        default: begin
                            n_idx   = CNT_W'(PIXEL_COUNT - 1);
                            n_state = S_LEAD;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                if (r_idx < r_cmd.stop) begin
                    w_wr_en = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (!i_res_full) begin
                    o_res_push      = 1'b1;
                    o_res.kind      = KIND_STATUS;
                    o_res.all_black = w_all_black;
                    o_res.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RDO: begin
                if (!i_res_full) begin
                    o_res_push        = 1'b1;
                    o_res.kind        = KIND_STATUS;
                    o_res.index_valid = r_cmd.rd_valid;
                    if (r_cmd.rd_valid) begin
                        o_res.read_green = w_colour[23:16];
                        o_res.read_red   = w_colour[15:8];
                        o_res.read_blue  = w_colour[7:0];
                    end
                    o_res.all_black = w_all_black;
                    o_res.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LEAD: begin
                if (!i_res_full) begin
                    o_res_push       = 1'b1;
                    o_res.kind       = KIND_GAP;
                    o_res.zero_bytes = 7'(LEAD_ZERO_BYTES);
                    o_res.all_black  = r_blk;
                    n_state          = S_PEM;
                end
            end
            S_PRD: n_state = S_PEM;
            S_PEM: begin
                if (!i_res_full) begin
                    o_res_push      = 1'b1;
                    o_res.kind      = KIND_PIXEL;
                    o_res.enc_green = enc_byte(w_colour[23:16]);
                    o_res.enc_red   = enc_byte(w_colour[15:8]);
                    o_res.enc_blue  = enc_byte(w_colour[7:0]);
                    o_res.all_black = r_blk;
                    if (r_idx == '0) begin
                        n_state = S_TAIL;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_TAIL: begin
                if (!i_res_full) begin
                    o_res_push       = 1'b1;
                    o_res.kind       = KIND_GAP;
                    o_res.zero_bytes = 7'(TAIL_ZERO_BYTES);
                    o_res.all_black  = r_blk;
                    o_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nz    <= '0;
        end else begin
            r_state <= n_state;
            if (w_wr_en) r_nz[w_wr_addr] <= (w_wr_data != 24'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_blk <= n_blk;
    end

    // pixel store; a pixel whose nonzero flag is clear reads as black
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_rdata <= r_mem[w_rd_addr];
        r_rd_nz <= r_nz[w_rd_addr];
    end

endmodule

FILE: rtl/core/lsfe_outq.sv
// Result queue between the sequencer and the result ports.
// Depends on lsfe_pkg.
module lsfe_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsfe_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output lsfe_pkg::t_res o_res
);
    import lsfe_pkg::*;

    t_res               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (!w_wr && w_rd) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wr_ptr] <= i_res;
    end

endmodule

FILE: rtl/core/rgb_led_strip_frame_encoder.sv
// LED strip frame encoder, top level: command queue, sequencer, result queue.
// Depends on lsfe_pkg, lsfe_front, lsfe_back, lsfe_outq, assert_macros.svh.
//
// Commands enter through a queue port: a beat is taken when push is high and
// full is low. Results leave through a queue port: the oldest result sits on
// the o_ ports while empty is low and is taken when pop is high.
// A two-entry command queue lets commands pile up while one is running; the
// sequencer runs one command at a time against a pixel store with one write
// port and one read port. What each command does once it reaches the sequencer:
//   fill / masked write: one pixel written per cycle, then a status result;
//   read: one status result; refresh: a read and an emit state per pixel,
//   the first read under the lead gap, between the lead and tail gaps.
// Refresh yields PIXEL_COUNT + 2 results; last marks the final one.
// When pop is held low the two-entry result queue fills and the sequencer
// waits in place; nothing is dropped. Reset empties both queues, returns the
// sequencer to idle and makes every pixel read as black at once.
`include "assert_macros.svh"

module rgb_led_strip_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_first,
    input  logic [7:0]  i_count,
    input  logic [7:0]  i_bound,
    input  logic [31:0] i_mask,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_blue,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_zero_bytes,
    output logic [23:0] o_enc_green,
    output logic [23:0] o_enc_red,
    output logic [23:0] o_enc_blue,
    output logic [7:0]  o_read_green,
    output logic [7:0]  o_read_red,
    output logic [7:0]  o_read_blue,
    output logic        o_index_valid,
    output logic        o_all_black,
    output logic        o_last
);
    import lsfe_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_push;
    t_res res_in;
    logic res_full;
    t_res res_out;

    lsfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_mode      (i_mode),
        .i_first     (i_first),
        .i_count     (i_count),
        .i_bound     (i_bound),
        .i_mask      (i_mask),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_blue      (i_blue),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    lsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    lsfe_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    assign o_kind        = res_out.kind;
    assign o_zero_bytes  = res_out.zero_bytes;
    assign o_enc_green   = res_out.enc_green;
    assign o_enc_red     = res_out.enc_red;
    assign o_enc_blue    = res_out.enc_blue;
    assign o_read_green  = res_out.read_green;
    assign o_read_red    = res_out.read_red;
    assign o_read_blue   = res_out.read_blue;
    assign o_index_valid = res_out.index_valid;
    assign o_all_black   = res_out.all_black;
    assign o_last        = res_out.last;

    `ASSERT_NEVER(a_push_into_full, i_clk, i_rst_n, res_push && res_full)
    `ASSERT_IMPL(a_pop_needs_cmd, i_clk, i_rst_n, cmd_pop, cmd_valid)
    `ASSERT_IMPL(a_pixel_not_last, i_clk, i_rst_n, !empty && o_kind == KIND_PIXEL, !o_last)
    `ASSERT_IMPL(a_kind_known, i_clk, i_rst_n, !empty, o_kind <= KIND_PIXEL)

endmodule

FILE: sim/lsfe_frame_checker.sv
// Checker for the LED strip frame encoder: keeps its own copy of the pixel colors,
// predicts every result beat from the accepted commands and compares them in order.
// Depends on lsfe_pkg.
module lsfe_frame_checker
    import lsfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_first,
    input  logic [7:0]  i_count,
    input  logic [7:0]  i_bound,
    input  logic [31:0] i_mask,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_blue,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_zero_bytes,
    input  logic [23:0] i_enc_green,
    input  logic [23:0] i_enc_red,
    input  logic [23:0] i_enc_blue,
    input  logic [7:0]  i_read_green,
    input  logic [7:0]  i_read_red,
    input  logic [7:0]  i_read_blue,
    input  logic        i_index_valid,
    input  logic        i_all_black,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    logic [23:0] pixel_rgb [PIXEL_COUNT];
    t_res        frame_due [$];
    int          mismatches = 0;
    int          beats_checked = 0;

    function automatic logic [23:0] sym_word(input logic [7:0] b);
        logic [23:0] w;
        w = '0;
        for (int k = 7; k >= 0; k--) begin
            w = {w[20:0], b[k] ? SYM_ONE : SYM_ZERO};
        end
        return w;
    endfunction

    function automatic logic strip_is_black();
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            if (pixel_rgb[i] != '0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_cmd(input logic [1:0] mode, input logic [7:0] first,
                               input logic [7:0] count, input logic [7:0] bound,
                               input logic [31:0] mask, input logic [23:0] colour);
        t_res r;
        int   stop;
        logic black;
        case (mode)
            MODE_FILL: begin
                if (first < PIXEL_COUNT) begin
                    stop = (count == 0) ? PIXEL_COUNT : int'(first) + int'(count);
                    if (stop > PIXEL_COUNT) stop = PIXEL_COUNT;
                    for (int i = first; i < stop; i++) pixel_rgb[i] = colour;
                end
            end
            MODE_MASKED: begin
                for (int i = first; i < bound && i < PIXEL_COUNT; i++) begin
                    pixel_rgb[i] = mask[i] ? colour : 24'h0;
                end
            end
            MODE_REFRESH: begin
                black = strip_is_black();
                r = '0;
                r.kind = KIND_GAP;
                r.zero_bytes = 7'(LEAD_ZERO_BYTES);
                r.all_black = black;
                frame_due.push_back(r);
                for (int p = PIXEL_COUNT - 1; p >= 0; p--) begin
                    r = '0;
                    r.kind = KIND_PIXEL;
                    r.enc_green = sym_word(pixel_rgb[p][23:16]);
                    r.enc_red = sym_word(pixel_rgb[p][15:8]);
                    r.enc_blue = sym_word(pixel_rgb[p][7:0]);
                    r.all_black = black;
                    frame_due.push_back(r);
                end
                r = '0;
                r.kind = KIND_GAP;
                r.zero_bytes = 7'(TAIL_ZERO_BYTES);
                r.all_black = black;
                r.last = 1'b1;
                frame_due.push_back(r);
            end
            default: ;
        endcase
        if (mode != MODE_REFRESH) begin
            r = '0;
            r.kind = KIND_STATUS;
            if (mode == MODE_READ && first < PIXEL_COUNT) begin
                r.read_green = pixel_rgb[first][23:16];
                r.read_red = pixel_rgb[first][15:8];
                r.read_blue = pixel_rgb[first][7:0];
                r.index_valid = 1'b1;
            end
            r.all_black = strip_is_black();
            r.last = 1'b1;
            frame_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < PIXEL_COUNT; i++) pixel_rgb[i] = '0;
            frame_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (frame_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end else begin
                    want = frame_due.pop_front();
                    check_field("kind", 24'(want.kind), 24'(i_kind));
                    check_field("zero_bytes", 24'(want.zero_bytes), 24'(i_zero_bytes));
                    check_field("enc_green", want.enc_green, i_enc_green);
                    check_field("enc_red", want.enc_red, i_enc_red);
                    check_field("enc_blue", want.enc_blue, i_enc_blue);
                    check_field("read_green", 24'(want.read_green), 24'(i_read_green));
                    check_field("read_red", 24'(want.read_red), 24'(i_read_red));
                    check_field("read_blue", 24'(want.read_blue), 24'(i_read_blue));
                    check_field("index_valid", 24'(want.index_valid), 24'(i_index_valid));
                    check_field("all_black", 24'(want.all_black), 24'(i_all_black));
                    check_field("last", 24'(want.last), 24'(i_last));
                    beats_checked++;
                end
            end
            if (i_push && !i_full) begin
                predict_cmd(i_mode, i_first, i_count, i_bound, i_mask,
                            {i_green, i_red, i_blue});
            end
        end
        o_errors <= mismatches;
        o_pending <= frame_due.size();
        o_checked <= beats_checked;
    end

endmodule

FILE: sim/rgb_led_strip_frame_encoder_tb.sv
// Testbench top for the LED strip frame encoder: clock, reset, command stimulus
// and result back-pressure; the verdict comes from lsfe_frame_checker.
// Depends on lsfe_pkg, lsfe_frame_checker and rgb_led_strip_frame_encoder.
module rgb_led_strip_frame_encoder_tb;
    import lsfe_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_first = '0;
    logic [7:0]  i_count = '0;
    logic [7:0]  i_bound = '0;
    logic [31:0] i_mask = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_blue = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [6:0]  o_zero_bytes;
    logic [23:0] o_enc_green;
    logic [23:0] o_enc_red;
    logic [23:0] o_enc_blue;
    logic [7:0]  o_read_green;
    logic [7:0]  o_read_red;
    logic [7:0]  o_read_blue;
    logic        o_index_valid;
    logic        o_all_black;
    logic        o_last;

    int   errors;
    int   pending;
    int   checked;
    int   mode_cnt [4] = '{0, 0, 0, 0};
    logic calm = 1'b0;
    logic long_stall_done = 1'b0;

    rgb_led_strip_frame_encoder dut (.*);

    lsfe_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_mode        (i_mode),
        .i_first       (i_first),
        .i_count       (i_count),
        .i_bound       (i_bound),
        .i_mask        (i_mask),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_blue        (i_blue),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_kind        (o_kind),
        .i_zero_bytes  (o_zero_bytes),
        .i_enc_green   (o_enc_green),
        .i_enc_red     (o_enc_red),
        .i_enc_blue    (o_enc_blue),
        .i_read_green  (o_read_green),
        .i_read_red    (o_read_red),
        .i_read_blue   (o_read_blue),
        .i_index_valid (o_index_valid),
        .i_all_black   (o_all_black),
        .i_last        (o_last),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input logic [1:0] md, input logic [7:0] fi, input logic [7:0] cn,
                         input logic [7:0] ei, input logic [31:0] mk,
                         input logic [7:0] g, input logic [7:0] r, input logic [7:0] b);
        int gap;
        push <= 1'b1;
        i_mode <= md;
        i_first <= fi;
        i_count <= cn;
        i_bound <= ei;
        i_mask <= mk;
        i_green <= g;
        i_red <= r;
        i_blue <= b;
        do @(posedge i_clk); while (full);
        mode_cnt[md]++;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_cmd();
        int          sel;
        int          cs;
        logic [7:0]  fi, cn, ei, g, r, b;
        logic [31:0] mk;
        sel = $urandom_range(0, 99);
        fi = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 16)) : 8'($urandom);
        cs = $urandom_range(0, 99);
        if (cs < 30) cn = '0;
        else if (cs < 85) cn = 8'($urandom_range(1, 16));
        else cn = 8'($urandom);
        ei = ($urandom_range(0, 9) < 7) ? fi + 8'($urandom_range(0, 17)) : 8'($urandom);
        mk = $urandom;
        cs = $urandom_range(0, 9);
        g = (cs == 0) ? 8'h00 : (cs == 1) ? 8'hff : 8'($urandom);
        r = (cs == 0) ? 8'h00 : (cs == 1) ? 8'hff : 8'($urandom);
        b = (cs == 0) ? 8'h00 : (cs == 1) ? 8'hff : 8'($urandom);
        if (sel < 8) issue(MODE_FILL, 8'd0, 8'd0, ei, mk, 8'h00, 8'h00, 8'h00);
        else if (sel < 35) issue(MODE_FILL, fi, cn, ei, mk, g, r, b);
        else if (sel < 60) issue(MODE_MASKED, fi, cn, ei, mk, g, r, b);
        else if (sel < 82) issue(MODE_READ, fi, cn, ei, mk, g, r, b);
        else issue(MODE_REFRESH, fi, cn, ei, mk, g, r, b);
    endtask

    // result side: random pop gaps plus one long hold-off to back the block up
    initial begin
        int hold;
        hold = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) hold = pick_gap();
            if (!long_stall_done && checked >= 200) begin
                hold = 400;
                long_stall_done = 1'b1;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(MODE_REFRESH, 8'd0, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_READ, 8'd0, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_READ, 8'd15, 8'd0, 8'd0, 32'h0, 8'hff, 8'hff, 8'hff);
        issue(MODE_READ, 8'd255, 8'd255, 8'd255, 32'hffff_ffff, 8'hff, 8'hff, 8'hff);
        issue(MODE_FILL, 8'd0, 8'd0, 8'd0, 32'h0, 8'hff, 8'hff, 8'hff);
        issue(MODE_READ, 8'd14, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_REFRESH, 8'd0, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_FILL, 8'd14, 8'd1, 8'd0, 32'h0, 8'h80, 8'h01, 8'h55);
        issue(MODE_FILL, 8'd10, 8'd200, 8'd0, 32'h0, 8'h12, 8'h34, 8'h56);
        issue(MODE_FILL, 8'd15, 8'd3, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_FILL, 8'd255, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_MASKED, 8'd0, 8'd0, 8'd15, 32'haaaa_5555, 8'h0f, 8'hf0, 8'ha5);
        issue(MODE_MASKED, 8'd5, 8'd0, 8'd5, 32'hffff_ffff, 8'h00, 8'h00, 8'h00);
        issue(MODE_MASKED, 8'd9, 8'd0, 8'd3, 32'hffff_ffff, 8'h00, 8'h00, 8'h00);
        issue(MODE_MASKED, 8'd12, 8'd0, 8'd255, 32'hffff_ffff, 8'h7e, 8'h81, 8'h3c);
        issue(MODE_MASKED, 8'd200, 8'd0, 8'd255, 32'hffff_ffff, 8'h00, 8'h00, 8'h00);
        issue(MODE_READ, 8'd14, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_READ, 8'd7, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_REFRESH, 8'd255, 8'd255, 8'd255, 32'hffff_ffff, 8'hff, 8'hff, 8'hff);
        issue(MODE_FILL, 8'd0, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_READ, 8'd3, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        issue(MODE_MASKED, 8'd0, 8'd0, 8'd32, 32'h0000_0000, 8'hff, 8'hff, 8'hff);
        issue(MODE_REFRESH, 8'd0, 8'd0, 8'd0, 32'h0, 8'h00, 8'h00, 8'h00);
        drain();

        for (int n = 0; n < 260; n++) begin
            calm = (n >= 90 && n < 130);
            if (n == 150) drain();
            random_cmd();
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d fills, %0d masked writes, %0d reads, %0d refreshes",
                 mode_cnt[MODE_FILL], mode_cnt[MODE_MASKED], mode_cnt[MODE_READ],
                 mode_cnt[MODE_REFRESH]);
        $display("%0d result beats checked, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("PASS rgb_led_strip_frame_encoder");
        end else begin
            $display("FAIL rgb_led_strip_frame_encoder");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL rgb_led_strip_frame_encoder");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lsfe_pkg.sv
rtl/core/lsfe_front.sv
rtl/core/lsfe_back.sv
rtl/core/lsfe_outq.sv
rtl/core/rgb_led_strip_frame_encoder.sv
sim/lsfe_frame_checker.sv
sim/rgb_led_strip_frame_encoder_tb.sv
